[hdl/telemetry_decimal_display_refresher_unit_defines.svh]
// Assertion macros for the display refresher top level.
// Relies on i_clk and i_rst_n being present in the including module.
`ifndef TELEMETRY_DECIMAL_DISPLAY_REFRESHER_UNIT_DEFINES_SVH
`define TELEMETRY_DECIMAL_DISPLAY_REFRESHER_UNIT_DEFINES_SVH

// same-cycle implication
`define TDDR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TDDR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/tddr_pkg.sv]
// Shared types, constants and control store for the display refresher.
// No dependencies.
package tddr_pkg;

    localparam int TDDR_MAX_ITEMS          = 8;
    localparam int TDDR_NUM_DISPLAYS       = 8;
    localparam int TDDR_DIGITS_PER_DISPLAY = 8;

    // sequencer steps
    localparam logic [2:0] S_WAIT  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_DIGIT = 3'd5;
    localparam logic [2:0] S_NEXT  = 3'd6;
    localparam logic [2:0] S_FLUSH = 3'd7;

    // branch conditions
    localparam logic [2:0] C_ALWAYS = 3'd0;
    localparam logic [2:0] C_START  = 3'd1;
    localparam logic [2:0] C_AT_END = 3'd2;
    localparam logic [2:0] C_CAND   = 3'd3;
    localparam logic [2:0] C_EMITS  = 3'd4;
    localparam logic [2:0] C_MORE   = 3'd5;

    typedef struct packed {
        logic       accept;
        logic       load;
        logic       mul;
        logic       digit;
        logic       next_idx;
        logic       flush;
        logic [2:0] cond;
        logic [2:0] tgt_t;
        logic [2:0] tgt_f;
    } t_uword;

    typedef struct packed {
        logic start;
        logic at_end;
        logic cand;
        logic emits;
        logic more;
        logic hold;
    } t_cond;

    function automatic t_uword tddr_rom(input logic [2:0] step);
        t_uword w;
        w = '0;
        case (step)
            S_WAIT: begin
                w.accept = 1'b1;
                w.cond   = C_START;
                w.tgt_t  = S_SCAN;
                w.tgt_f  = S_WAIT;
            end
            S_SCAN: begin
                w.cond  = C_AT_END;
                w.tgt_t = S_FLUSH;
                w.tgt_f = S_CHECK;
            end
            S_CHECK: begin
                w.cond  = C_CAND;
                w.tgt_t = S_LOAD;
                w.tgt_f = S_NEXT;
            end
            S_LOAD: begin
                w.load  = 1'b1;
                w.cond  = C_EMITS;
                w.tgt_t = S_MUL;
                w.tgt_f = S_NEXT;
            end
            S_MUL: begin
                w.mul   = 1'b1;
                w.cond  = C_ALWAYS;
                w.tgt_t = S_DIGIT;
                w.tgt_f = S_DIGIT;
            end
            S_DIGIT: begin
                w.digit = 1'b1;
                w.cond  = C_MORE;
                w.tgt_t = S_MUL;
                w.tgt_f = S_NEXT;
            end
            S_NEXT: begin
                w.next_idx = 1'b1;
                w.cond     = C_ALWAYS;
                w.tgt_t    = S_SCAN;
                w.tgt_f    = S_SCAN;
            end
            S_FLUSH: begin
                w.flush = 1'b1;
                w.cond  = C_ALWAYS;
                w.tgt_t = S_WAIT;
                w.tgt_f = S_WAIT;
            end
            default: begin
                w.cond  = C_ALWAYS;
                w.tgt_t = S_WAIT;
                w.tgt_f = S_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

[hdl/tddr_div10.sv]
// Divide-by-ten unit: reciprocal multiply registered, remainder by shift-subtract.
// Depends on nothing; quotient valid the cycle after i_load.
module tddr_div10 (
    input  logic        i_clk,
    input  logic        i_load,
    input  logic [31:0] i_q,
    output logic [31:0] o_quot,
    output logic [3:0]  o_rem
);

    localparam logic [31:0] RECIP = 32'hCCCC_CCCD;

    logic [63:0] r_prod;
    logic [63:0] n_prod;
    logic [31:0] w_diff;

    assign n_prod = i_q * RECIP;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= n_prod;
        end
    end

    // floor(q * 0xCCCCCCCD / 2^35) is exact for all 32-bit q
    assign o_quot = {3'b000, r_prod[63:35]};
    assign w_diff = i_q - {o_quot[28:0], 3'b000} - {o_quot[30:0], 1'b0};
    assign o_rem  = w_diff[3:0];

endmodule

[hdl/tddr_seq.sv]
// Microcode sequencer: step counter, control store lookup and branch select.
// Depends on tddr_pkg.
module tddr_seq
    import tddr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cond  i_cond,
    output t_uword o_uw
);

    logic [2:0] r_step;
    logic [2:0] n_step;
    logic       w_take;

    assign o_uw = tddr_rom(r_step);

    always_comb begin
        case (o_uw.cond)
            C_ALWAYS: w_take = 1'b1;
            C_START:  w_take = i_cond.start;
            C_AT_END: w_take = i_cond.at_end;
            C_CAND:   w_take = i_cond.cand;
            C_EMITS:  w_take = i_cond.emits;
            C_MORE:   w_take = i_cond.more;
            default:  w_take = 1'b1;
        endcase
    end

    always_comb begin
        if (i_cond.hold) begin
            n_step = r_step;
        end else if (w_take) begin
            n_step = o_uw.tgt_t;
        end else begin
            n_step = o_uw.tgt_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

[hdl/telemetry_decimal_display_refresher_unit.sv]
// Display refresher top level: item table, digit datapath, output staging.
// Depends on tddr_pkg, tddr_seq, tddr_div10 and the assertion macro header.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries set and refresh requests.
//   A set stores one table slot. A refresh on a dirty
//   table walks the slots in order and produces one output item per digit
//   write on the output channel (o_out_valid / i_out_stall), least
//   significant digit first; last_write flags the final write of the refresh.
//   Requests are taken only while the sequencer sits in its wait step, so
//   o_in_stall is high for the whole refresh.
//   Steps: each digit passes through a reciprocal multiply step, then a
//   digit and quotient update step; a loaded slot also passes the scan,
//   check, load and next steps, a skipped slot scan, check and next, and the
//   refresh closes with a scan and a flush step. One digit is held back in a
//   staging register so the last write can be marked; the first output item
//   appears once the second digit is produced or the walk ends.
//   Receiver stall: output register holds; the sequencer waits in its digit
//   or flush step until the staged item can move.
//   Reset: all slots invalid, no changed marks, table dirty, output idle.
`include "telemetry_decimal_display_refresher_unit_defines.svh"
module telemetry_decimal_display_refresher_unit
    import tddr_pkg::*;
#(
    parameter int MAX_ITEMS          = TDDR_MAX_ITEMS,
    parameter int NUM_DISPLAYS       = TDDR_NUM_DISPLAYS,
    parameter int DIGITS_PER_DISPLAY = TDDR_DIGITS_PER_DISPLAY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [2:0]  i_item_index,
    input  logic [2:0]  i_display_index,
    input  logic [2:0]  i_start_position,
    input  logic [3:0]  i_digit_count,
    input  logic [3:0]  i_point_position,
    input  logic [31:0] i_number_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_target_display,
    output logic [2:0]  o_digit_position,
    output logic [3:0]  o_digit_code,
    output logic        o_blank_digit,
    output logic        o_point_lit,
    output logic        o_last_write
);

    localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    t_uword uw;
    t_cond  w_cond;

    // item table
    logic          r_valid   [MAX_ITEMS];
    logic          r_changed [MAX_ITEMS];
    logic [2:0]    r_disp    [MAX_ITEMS];
    logic [2:0]    r_start   [MAX_ITEMS];
    logic [3:0]    r_count   [MAX_ITEMS];
    logic [3:0]    r_point   [MAX_ITEMS];
    logic [31:0]   r_value   [MAX_ITEMS];
    logic          r_dirty;

    logic [CW-1:0] r_idx;
    logic [IW-1:0] w_slot;
    logic [IW-1:0] w_set_slot;
    logic [31:0]   r_q;
    logic [3:0]    r_k;

    // staged and output items
    logic          r_pend_valid;
    logic [2:0]    r_pend_disp;
    logic [2:0]    r_pend_pos;
    logic [3:0]    r_pend_code;
    logic          r_pend_blank;
    logic          r_pend_point;
    logic          r_out_valid;
    logic          n_out_valid;
    logic [2:0]    r_out_disp;
    logic [2:0]    r_out_pos;
    logic [3:0]    r_out_code;
    logic          r_out_blank;
    logic          r_out_point;
    logic          r_out_last;

    logic          w_in_acc;
    logic          w_set;
    logic          w_blocked;
    logic          w_push;
    logic          w_flush;
    logic          w_move;
    logic [31:0]   w_quot;
    logic [3:0]    w_rem;
    logic [4:0]    w_pos;
    logic          w_blank;

    tddr_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (w_cond),
        .o_uw    (uw)
    );

    tddr_div10 u_div10 (
        .i_clk  (i_clk),
        .i_load (uw.mul),
        .i_q    (r_q),
        .o_quot (w_quot),
        .o_rem  (w_rem)
    );

    assign o_in_stall = !uw.accept;
    assign w_in_acc   = i_in_valid && uw.accept;
    assign w_set      = w_in_acc && !i_req_type && ({1'b0, i_item_index} < 4'(MAX_ITEMS));
    assign w_set_slot = i_item_index[IW-1:0];
    assign w_slot     = r_idx[IW-1:0];

    assign w_pos   = {2'b00, r_start[w_slot]} + {1'b0, r_k};
    assign w_blank = (r_k != 4'd0) && (r_q == 32'd0);

    assign w_blocked = r_pend_valid && r_out_valid && i_out_stall;
    assign w_push    = uw.digit && !w_blocked;
    assign w_flush   = uw.flush && !w_blocked;
    assign w_move    = (w_push || w_flush) && r_pend_valid;

    always_comb begin
        w_cond.start  = w_in_acc && i_req_type && r_dirty;
        w_cond.at_end = (r_idx == CW'(MAX_ITEMS));
        w_cond.cand   = r_valid[w_slot] && r_changed[w_slot];
        w_cond.emits  = (r_count[w_slot] != 4'd0)
                     && ({1'b0, r_disp[w_slot]} < 4'(NUM_DISPLAYS))
                     && ({1'b0, r_start[w_slot]} < 4'(DIGITS_PER_DISPLAY));
        w_cond.more   = (({1'b0, r_k} + 5'd1) < {1'b0, r_count[w_slot]})
                     && ((w_pos + 5'd1) < 5'(DIGITS_PER_DISPLAY));
        w_cond.hold   = (uw.digit || uw.flush) && w_blocked;
    end

    assign n_out_valid = w_move || (r_out_valid && i_out_stall);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty      <= 1'b1;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < MAX_ITEMS; i++) begin
                r_valid[i]   <= 1'b0;
                r_changed[i] <= 1'b0;
            end
        end else begin
            r_out_valid <= n_out_valid;
            if (w_set) begin
                r_valid[w_set_slot]   <= 1'b1;
                r_changed[w_set_slot] <= 1'b1;
                r_dirty               <= 1'b1;
            end
            if (w_cond.start) begin
                r_dirty <= 1'b0;
                r_idx   <= '0;
            end
            if (uw.load) begin
                r_changed[w_slot] <= 1'b0;
            end
            if (uw.next_idx) begin
                r_idx <= r_idx + CW'(1);
            end
            if (w_push) begin
                r_pend_valid <= 1'b1;
            end else if (w_flush) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_set) begin
            r_disp[w_set_slot]  <= i_display_index;
            r_start[w_set_slot] <= i_start_position;
            r_count[w_set_slot] <= i_digit_count;
            r_point[w_set_slot] <= i_point_position;
            r_value[w_set_slot] <= i_number_value;
        end
        if (uw.load) begin
            r_q <= r_value[w_slot];
            r_k <= 4'd0;
        end
        if (w_push) begin
            r_pend_disp  <= r_disp[w_slot];
            r_pend_pos   <= w_pos[2:0];
            r_pend_code  <= w_blank ? 4'd0 : w_rem;
            r_pend_blank <= w_blank;
            r_pend_point <= !w_blank && (r_k == r_point[w_slot]);
            r_q          <= w_quot;
            r_k          <= r_k + 4'd1;
        end
        if (w_move) begin
            r_out_disp  <= r_pend_disp;
            r_out_pos   <= r_pend_pos;
            r_out_code  <= r_pend_code;
            r_out_blank <= r_pend_blank;
            r_out_point <= r_pend_point;
            r_out_last  <= w_flush;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_target_display = r_out_disp;
    assign o_digit_position = r_out_pos;
    assign o_digit_code     = r_out_code;
    assign o_blank_digit    = r_out_blank;
    assign o_point_lit      = r_out_point;
    assign o_last_write     = r_out_last;

    `TDDR_ASSERT_IMP(a_blank_clean, o_out_valid && o_blank_digit, !o_point_lit && (o_digit_code == 4'd0), "blank item carries digit or point")
    `TDDR_ASSERT_IMP(a_wait_no_pend, uw.accept, !r_pend_valid, "staged item left over while taking requests")
    `TDDR_ASSERT_NXT(a_push_stages, w_push, r_pend_valid, "digit produced but not staged")

endmodule

[test/telemetry_decimal_display_refresher_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for telemetry_decimal_display_refresher_unit: queued set and
// refresh requests, a predictor of the digit writes and a field-by-field monitor.
// Depends on tddr_pkg and the refresher RTL.
module telemetry_decimal_display_refresher_unit_test
    import tddr_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 250;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_TRIGGER   = 150;
    localparam int TOTAL_ITEMS    = 270;
    localparam int MAX_REPORTS    = 100;

    typedef enum logic {REQ_SET = 1'b0, REQ_REFRESH = 1'b1} t_req_kind;
    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PULSE} t_stall_mode;

    typedef struct packed {
        t_req_kind   kind;
        logic [2:0]  slot;
        logic [2:0]  display;
        logic [2:0]  start;
        logic [3:0]  count;
        logic [3:0]  point;
        logic [31:0] value;
    } t_request;

    typedef struct packed {
        logic [2:0] display;
        logic [2:0] position;
        logic [3:0] code;
        logic       blank;
        logic       point;
        logic       last;
    } t_digit_write;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_in_valid       = 1'b0;
    logic        o_in_stall;
    logic        i_req_type       = 1'b0;
    logic [2:0]  i_item_index     = '0;
    logic [2:0]  i_display_index  = '0;
    logic [2:0]  i_start_position = '0;
    logic [3:0]  i_digit_count    = '0;
    logic [3:0]  i_point_position = '0;
    logic [31:0] i_number_value   = '0;
    logic        o_out_valid;
    logic        i_out_stall      = 1'b0;
    logic [2:0]  o_target_display;
    logic [2:0]  o_digit_position;
    logic [3:0]  o_digit_code;
    logic        o_blank_digit;
    logic        o_point_lit;
    logic        o_last_write;

    // predicted table state
    logic        slot_valid   [TDDR_MAX_ITEMS];
    logic [2:0]  slot_display [TDDR_MAX_ITEMS];
    logic [2:0]  slot_start   [TDDR_MAX_ITEMS];
    logic [3:0]  slot_count   [TDDR_MAX_ITEMS];
    logic [3:0]  slot_point   [TDDR_MAX_ITEMS];
    logic [31:0] slot_value   [TDDR_MAX_ITEMS];
    logic        slot_changed [TDDR_MAX_ITEMS];
    logic        table_dirty;

    t_request     pending_requests[$];
    t_digit_write expected_writes[$];
    t_request     current_req = '0;

    int          requests_accepted = 0;
    int          writes_seen       = 0;
    int          mismatches        = 0;
    int          burst_left        = 0;
    int          gap_left          = 0;
    int          hold_left         = 0;
    bit          hold_done         = 1'b0;
    int          segment_left      = 0;
    t_stall_mode stall_mode        = STALL_NONE;
    bit          pulse_phase       = 1'b0;
    int          idle_cycles       = 0;

    telemetry_decimal_display_refresher_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_item_index     (i_item_index),
        .i_display_index  (i_display_index),
        .i_start_position (i_start_position),
        .i_digit_count    (i_digit_count),
        .i_point_position (i_point_position),
        .i_number_value   (i_number_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_target_display (o_target_display),
        .o_digit_position (o_digit_position),
        .o_digit_code     (o_digit_code),
        .o_blank_digit    (o_blank_digit),
        .o_point_lit      (o_point_lit),
        .o_last_write     (o_last_write)
    );

    initial begin : clock_gen
        forever #5 i_clk = ~i_clk;
    end

    task automatic predict_digit_writes(input t_request r);
        t_digit_write w;
        logic [31:0]  q;
        int           i;
        int           k;
        int           pos;
        int           n;
        n = 0;
        if (r.kind == REQ_SET) begin
            slot_valid[r.slot]   = 1'b1;
            slot_display[r.slot] = r.display;
            slot_start[r.slot]   = r.start;
            slot_count[r.slot]   = r.count;
            slot_point[r.slot]   = r.point;
            slot_value[r.slot]   = r.value;
            slot_changed[r.slot] = 1'b1;
            table_dirty          = 1'b1;
        end else if (table_dirty) begin
            table_dirty = 1'b0;
            for (i = 0; i < TDDR_MAX_ITEMS; i++) begin
                if (slot_valid[i] && slot_changed[i]) begin
                    slot_changed[i] = 1'b0;
                    q = slot_value[i];
                    for (k = 0; k < slot_count[i]; k++) begin
                        pos = slot_start[i] + k;
                        if (pos < TDDR_DIGITS_PER_DISPLAY && slot_display[i] < TDDR_NUM_DISPLAYS) begin
                            w.display  = slot_display[i];
                            w.position = pos[2:0];
                            w.blank    = (k > 0) && (q == 32'd0);
                            w.code     = w.blank ? 4'd0 : 4'(q % 32'd10);
                            w.point    = !w.blank && (k == slot_point[i]);
                            w.last     = 1'b0;
                            expected_writes.push_back(w);
                            n++;
                        end
                        q = q / 32'd10;
                    end
                end
            end
            if (n > 0) begin
                w = expected_writes.pop_back();
                w.last = 1'b1;
                expected_writes.push_back(w);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic push_set(input logic [2:0] slot, input logic [2:0] display,
                            input logic [2:0] start, input logic [3:0] count,
                            input logic [3:0] point, input logic [31:0] value);
        t_request r;
        r.kind    = REQ_SET;
        r.slot    = slot;
        r.display = display;
        r.start   = start;
        r.count   = count;
        r.point   = point;
        r.value   = value;
        pending_requests.push_back(r);
    endtask

    // refresh ignores everything but the request type, so the rest is junk
    task automatic push_refresh();
        t_request r;
        r.kind    = REQ_REFRESH;
        r.slot    = 3'($urandom);
        r.display = 3'($urandom);
        r.start   = 3'($urandom);
        r.count   = 4'($urandom);
        r.point   = 4'($urandom);
        r.value   = $urandom;
        pending_requests.push_back(r);
    endtask

    task automatic push_random_set(input logic [2:0] slot);
        logic [31:0] v;
        logic [3:0]  count;
        logic [3:0]  point;
        int          j;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 9);
            1: v = $urandom_range(0, 99999);
            2: v = 32'hFFFF_FFFF - $urandom_range(0, 3);
            3: begin
                v = 32'd1;
                for (j = $urandom_range(0, 9); j > 0; j--) v = v * 32'd10;
                if ($urandom_range(0, 1)) v = v - 32'd1;
            end
            default: v = $urandom;
        endcase
        count = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(0, 15));
        point = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(0, 15));
        push_set(slot, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), count, point, v);
    endtask

    initial begin : stimulus
        int total;
        int i;
        int n;

        for (i = 0; i < TDDR_MAX_ITEMS; i++) begin
            slot_valid[i]   = 1'b0;
            slot_changed[i] = 1'b0;
        end
        table_dirty = 1'b1;

        // directed: empty table, clean table, field extremes, overwrite, zero count
        push_refresh();
        push_refresh();
        push_set(3'd0, 3'd0, 3'd0, 4'd8, 4'd0, 32'd0);
        push_set(3'd7, 3'd7, 3'd7, 4'd8, 4'd8, 32'hFFFF_FFFF);
        push_set(3'd3, 3'd5, 3'd2, 4'd15, 4'd15, 32'd1234567890);
        push_set(3'd1, 3'd2, 3'd0, 4'd0, 4'd0, 32'd42);
        push_refresh();
        push_refresh();
        push_set(3'd2, 3'd3, 3'd0, 4'd8, 4'd3, 32'd99999999);
        push_set(3'd2, 3'd3, 3'd1, 4'd3, 4'd2, 32'd100);
        push_set(3'd4, 3'd1, 3'd4, 4'd4, 4'd1, 32'd7);
        push_refresh();
        push_set(3'd1, 3'd6, 3'd3, 4'd0, 4'd4, 32'd5);
        push_refresh();
        for (i = 0; i < TDDR_MAX_ITEMS; i++)
            push_set(3'(i), 3'(i), 3'd0, 4'd8, 4'($urandom_range(0, 7)),
                     $urandom | 32'h8000_0000);
        push_refresh();

        total = TOTAL_ITEMS;
        while (pending_requests.size() < total) begin
            case ($urandom_range(0, 9))
                7: push_refresh();
                8: push_random_set(3'($urandom_range(0, 7)));
                9: begin
                    for (i = 0; i < TDDR_MAX_ITEMS; i++) push_random_set(3'(i));
                    push_refresh();
                end
                default: begin
                    n = $urandom_range(1, 6);
                    for (i = 0; i < n; i++) push_random_set(3'($urandom_range(0, 7)));
                    push_refresh();
                    if ($urandom_range(0, 3) == 0) push_refresh();
                end
            endcase
        end
        total = pending_requests.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_accepted < total) @(posedge i_clk);
        while (expected_writes.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    always @(posedge i_clk) begin : driver
        logic offer;
        if (i_rst_n) begin
            offer = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                predict_digit_writes(current_req);
                requests_accepted++;
                offer = 1'b0;
            end
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_requests.size() > 0) begin
                    current_req = pending_requests.pop_front();
                    offer = 1'b1;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 16);
                        case ($urandom_range(0, 5))
                            0, 1, 2: gap_left = 0;
                            3, 4:    gap_left = $urandom_range(1, 4);
                            default: gap_left = $urandom_range(8, 30);
                        endcase
                    end
                end
            end
            i_in_valid       <= offer;
            i_req_type       <= current_req.kind;
            i_item_index     <= current_req.slot;
            i_display_index  <= current_req.display;
            i_start_position <= current_req.start;
            i_digit_count    <= current_req.count;
            i_point_position <= current_req.point;
            i_number_value   <= current_req.value;
        end
    end

    always @(posedge i_clk) begin : receiver
        logic stall_next;
        if (!i_rst_n) begin
            stall_next = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
        end else if (!hold_done && writes_seen >= HOLD_TRIGGER) begin
            // long hold-off mid refresh so the block backs up into its input
            hold_done  = 1'b1;
            hold_left  = HOLD_CYCLES;
            stall_next = 1'b1;
        end else begin
            if (segment_left == 0) begin
                stall_mode   = t_stall_mode'($urandom_range(0, 3));
                segment_left = $urandom_range(10, 80);
            end else begin
                segment_left--;
            end
            pulse_phase = ~pulse_phase;
            case (stall_mode)
                STALL_NONE:  stall_next = 1'b0;
                STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
                STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
                default:     stall_next = pulse_phase;
            endcase
        end
        i_out_stall <= stall_next;
    end

    always @(posedge i_clk) begin : monitor
        t_digit_write want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            writes_seen++;
            if (expected_writes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected digit write, expected none, actual %0d/%0d/%0d",
                             $time, o_target_display, o_digit_position, o_digit_code);
            end else begin
                want = expected_writes.pop_front();
                check_field("target_display", 32'(want.display), 32'(o_target_display));
                check_field("digit_position", 32'(want.position), 32'(o_digit_position));
                check_field("digit_code", 32'(want.code), 32'(o_digit_code));
                check_field("blank_digit", 32'(want.blank), 32'(o_blank_digit));
                check_field("point_lit", 32'(want.point), 32'(o_point_lit));
                check_field("last_write", 32'(want.last), 32'(o_last_write));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule

[files.f]
+incdir+hdl
hdl/tddr_pkg.sv
hdl/tddr_div10.sv
hdl/tddr_seq.sv
hdl/telemetry_decimal_display_refresher_unit.sv
test/telemetry_decimal_display_refresher_unit_test.sv
